// File: rtl/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    // Field and datapath widths
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned PROD_W     = COORD_W + COEF_W;
    localparam int unsigned SUM_W      = PROD_W + 2;
    localparam int unsigned MAG_W      = PROD_W;
    localparam int unsigned FRAC_SHIFT = 16;
    localparam int unsigned CONST_W    = COEF_W + FRAC_SHIFT;

    // The quotient n*2^17/d is formed over bits 32..0; anything above is overflow.
    localparam int unsigned QUOT_W     = 33;
    localparam int unsigned LO_W       = FRAC_SHIFT;

    // Saturation magnitudes of the Q16.16 result
    localparam logic [COORD_W-1:0] SAT_POS_MAG = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_NEG_MAG = 32'h8000_0000;

    // Configuration port
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned REG_LSB    = 3;

    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_ROW2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_COLUMN2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COEF_CORNER  = 3'd4;

    // Identity matrix after reset
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW0    = 64'h0000_0000_0100_0000;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW1    = 64'h0100_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW2    = 64'h0000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_COLUMN2 = 64'h0000_0000_0000_0000;
    localparam logic [COEF_W-1:0]     RST_COEF_CORNER  = 32'h0100_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;

endpackage

`default_nettype wire

// File: rtl/hpt_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hpt_point_if;
    logic            valid;
    logic            ready;
    hpt_pkg::t_coord point_x;
    hpt_pkg::t_coord point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface hpt_result_if;
    logic            valid;
    logic            ready;
    hpt_pkg::t_coord out_x;
    hpt_pkg::t_coord out_y;
    logic            w_zero;
    logic            clipped;

    modport source (output valid, output out_x, output out_y, output w_zero,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input w_zero,
                    input clipped, output ready);
endinterface

`default_nettype wire

// File: rtl/homogeneous_point_transform_2d_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps each Q16.16 point (x, y) through the 3x3 matrix held in the APB registers and
// returns x'/w and y'/w in Q16.16, rounded half away from zero and saturated (clipped
// flags saturation; w_zero flags w == 0 and forces both coordinates to zero). The
// pipeline takes one point per clock while the output is not stalled. It has one stage
// of 32x32 multiplies, one of three-term sums, one of sign and magnitude, one overflow
// check, 33 restoring-divider stages (one quotient bit each, shared divisor for x and
// y), one rounding stage and the output register. A stall at the output freezes the
// whole pipeline; input ready drops only while a finished result sits in the output
// register untaken. Write the matrix only while no point is in flight.
module homogeneous_point_transform_2d_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    hpt_point_if.sink                        i_point,
    hpt_result_if.source                     o_result,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [hpt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire [hpt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hpt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int unsigned QW     = hpt_pkg::QUOT_W;
    localparam int unsigned MW     = hpt_pkg::MAG_W;
    localparam int unsigned CW     = hpt_pkg::COORD_W;
    localparam int unsigned LW     = hpt_pkg::LO_W;
    localparam int unsigned STAGES = 3 + QW + 1 + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [hpt_pkg::CFG_DATA_W-1:0] r_coef_row0;
    logic [hpt_pkg::CFG_DATA_W-1:0] r_coef_row1;
    logic [hpt_pkg::CFG_DATA_W-1:0] r_coef_row2;
    logic [hpt_pkg::CFG_DATA_W-1:0] r_coef_column2;
    logic [hpt_pkg::COEF_W-1:0]     r_coef_corner;

    logic                          w_cfg_wr;
    logic [hpt_pkg::REG_IDX_W-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[hpt_pkg::CFG_ADDR_W-1:hpt_pkg::REG_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_row0    <= hpt_pkg::RST_COEF_ROW0;
            r_coef_row1    <= hpt_pkg::RST_COEF_ROW1;
            r_coef_row2    <= hpt_pkg::RST_COEF_ROW2;
            r_coef_column2 <= hpt_pkg::RST_COEF_COLUMN2;
            r_coef_corner  <= hpt_pkg::RST_COEF_CORNER;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                hpt_pkg::REG_COEF_ROW0:    r_coef_row0    <= pwdata;
                hpt_pkg::REG_COEF_ROW1:    r_coef_row1    <= pwdata;
                hpt_pkg::REG_COEF_ROW2:    r_coef_row2    <= pwdata;
                hpt_pkg::REG_COEF_COLUMN2: r_coef_column2 <= pwdata;
                hpt_pkg::REG_COEF_CORNER:  r_coef_corner  <= pwdata[hpt_pkg::COEF_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            hpt_pkg::REG_COEF_ROW0:    prdata = r_coef_row0;
            hpt_pkg::REG_COEF_ROW1:    prdata = r_coef_row1;
            hpt_pkg::REG_COEF_ROW2:    prdata = r_coef_row2;
            hpt_pkg::REG_COEF_COLUMN2: prdata = r_coef_column2;
            hpt_pkg::REG_COEF_CORNER:
                prdata = hpt_pkg::CFG_DATA_W'(r_coef_corner);
            default:                   prdata = '0;
        endcase
    end

    hpt_pkg::t_coef w_m00, w_m01, w_m10, w_m11, w_m20, w_m21, w_m02, w_m12, w_m22;
    logic signed [hpt_pkg::CONST_W-1:0] w_c20, w_c21, w_c22;

    assign w_m00 = r_coef_row0[31:0];
    assign w_m01 = r_coef_row0[63:32];
    assign w_m10 = r_coef_row1[31:0];
    assign w_m11 = r_coef_row1[63:32];
    assign w_m20 = r_coef_row2[31:0];
    assign w_m21 = r_coef_row2[63:32];
    assign w_m02 = r_coef_column2[31:0];
    assign w_m12 = r_coef_column2[63:32];
    assign w_m22 = r_coef_corner;

    // Constant term: coefficient times the homogeneous one (1.0 in Q16.16)
    assign w_c20 = {w_m20, {hpt_pkg::FRAC_SHIFT{1'b0}}};
    assign w_c21 = {w_m21, {hpt_pkg::FRAC_SHIFT{1'b0}}};
    assign w_c22 = {w_m22, {hpt_pkg::FRAC_SHIFT{1'b0}}};

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic              w_en;

    assign w_en          = !(r_vld[STAGES-1] && !o_result.ready);
    assign i_point.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_point.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products, stage 2: sums, stage 3: sign and magnitude
    // ------------------------------------------------------------------
    logic signed [hpt_pkg::PROD_W-1:0] r_s1_x0, r_s1_y0, r_s1_x1, r_s1_y1, r_s1_x2, r_s1_y2;
    logic signed [hpt_pkg::SUM_W-1:0]  r_s2_x, r_s2_y, r_s2_w;
    logic [MW-1:0] r_s3_nx, r_s3_ny, r_s3_dw;
    logic          r_s3_negx, r_s3_negy, r_s3_wz;

    function automatic logic [MW-1:0] f_abs(input logic signed [hpt_pkg::SUM_W-1:0] v);
        logic [hpt_pkg::SUM_W-1:0] a;
        a = v[hpt_pkg::SUM_W-1] ? hpt_pkg::SUM_W'(-v) : hpt_pkg::SUM_W'(v);
        return a[MW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_x0 <= i_point.point_x * w_m00;
            r_s1_y0 <= i_point.point_y * w_m10;
            r_s1_x1 <= i_point.point_x * w_m01;
            r_s1_y1 <= i_point.point_y * w_m11;
            r_s1_x2 <= i_point.point_x * w_m02;
            r_s1_y2 <= i_point.point_y * w_m12;

            r_s2_x <= hpt_pkg::SUM_W'(r_s1_x0) + hpt_pkg::SUM_W'(r_s1_y0)
                    + hpt_pkg::SUM_W'(w_c20);
            r_s2_y <= hpt_pkg::SUM_W'(r_s1_x1) + hpt_pkg::SUM_W'(r_s1_y1)
                    + hpt_pkg::SUM_W'(w_c21);
            r_s2_w <= hpt_pkg::SUM_W'(r_s1_x2) + hpt_pkg::SUM_W'(r_s1_y2)
                    + hpt_pkg::SUM_W'(w_c22);

            r_s3_nx   <= f_abs(r_s2_x);
            r_s3_ny   <= f_abs(r_s2_y);
            r_s3_dw   <= f_abs(r_s2_w);
            r_s3_negx <= r_s2_x[hpt_pkg::SUM_W-1] ^ r_s2_w[hpt_pkg::SUM_W-1];
            r_s3_negy <= r_s2_y[hpt_pkg::SUM_W-1] ^ r_s2_w[hpt_pkg::SUM_W-1];
            r_s3_wz   <= (r_s2_w == '0);
        end
    end

    // ------------------------------------------------------------------
    // Divider: entry 0 is the overflow check, entries 1..QW one quotient bit each
    // ------------------------------------------------------------------
    logic [MW-1:0] r_rem_x [0:QW];
    logic [MW-1:0] r_rem_y [0:QW];
    logic [MW-1:0] r_dw    [0:QW];
    logic [LW-1:0] r_lo_x  [0:QW];
    logic [LW-1:0] r_lo_y  [0:QW];
    logic [QW-1:0] r_q_x   [0:QW];
    logic [QW-1:0] r_q_y   [0:QW];
    logic          r_ov_x  [0:QW];
    logic          r_ov_y  [0:QW];
    logic          r_neg_x [0:QW];
    logic          r_neg_y [0:QW];
    logic          r_wz    [0:QW];

    // A quotient of 2^33 or more rounds beyond any Q16.16 value: flag it up front.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ov_x[0]  <= {{LW{1'b0}}, r_s3_nx} >= {r_s3_dw, {LW{1'b0}}};
            r_ov_y[0]  <= {{LW{1'b0}}, r_s3_ny} >= {r_s3_dw, {LW{1'b0}}};
            r_rem_x[0] <= {{LW{1'b0}}, r_s3_nx[MW-1:LW]};
            r_rem_y[0] <= {{LW{1'b0}}, r_s3_ny[MW-1:LW]};
            r_lo_x[0]  <= r_s3_nx[LW-1:0];
            r_lo_y[0]  <= r_s3_ny[LW-1:0];
            r_dw[0]    <= r_s3_dw;
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_neg_x[0] <= r_s3_negx;
            r_neg_y[0] <= r_s3_negy;
            r_wz[0]    <= r_s3_wz;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        localparam int unsigned J = k - 1;

        logic          w_bx, w_by;
        logic [MW:0]   w_tx, w_ty, w_dx, w_dy;
        logic          w_gex, w_gey;

        // Numerator bits below the initial remainder, then zeros for the fraction
        if (J < LW) begin : g_feed
            assign w_bx = r_lo_x[k-1][LW-1-J];
            assign w_by = r_lo_y[k-1][LW-1-J];
        end else begin : g_zero
            assign w_bx = 1'b0;
            assign w_by = 1'b0;
        end

        always_comb begin
            w_tx  = {r_rem_x[k-1], w_bx};
            w_ty  = {r_rem_y[k-1], w_by};
            w_dx  = w_tx - {1'b0, r_dw[k-1]};
            w_dy  = w_ty - {1'b0, r_dw[k-1]};
            w_gex = w_tx >= {1'b0, r_dw[k-1]};
            w_gey = w_ty >= {1'b0, r_dw[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem_x[k] <= w_gex ? w_dx[MW-1:0] : w_tx[MW-1:0];
                r_rem_y[k] <= w_gey ? w_dy[MW-1:0] : w_ty[MW-1:0];
                r_q_x[k]   <= {r_q_x[k-1][QW-2:0], w_gex};
                r_q_y[k]   <= {r_q_y[k-1][QW-2:0], w_gey};
                r_lo_x[k]  <= r_lo_x[k-1];
                r_lo_y[k]  <= r_lo_y[k-1];
                r_dw[k]    <= r_dw[k-1];
                r_ov_x[k]  <= r_ov_x[k-1];
                r_ov_y[k]  <= r_ov_y[k-1];
                r_neg_x[k] <= r_neg_x[k-1];
                r_neg_y[k] <= r_neg_y[k-1];
                r_wz[k]    <= r_wz[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Round half away from zero, saturate, then apply sign
    // ------------------------------------------------------------------
    logic [QW:0]   w_inc_x, w_inc_y;
    logic [QW-1:0] w_rnd_x, w_rnd_y;
    logic [CW-1:0] w_lim_x, w_lim_y;
    logic          w_clip_x, w_clip_y;

    logic [CW-1:0] r_mag_x, r_mag_y;
    logic          r_rc_x, r_rc_y, r_rneg_x, r_rneg_y, r_rwz;

    always_comb begin
        w_inc_x  = {1'b0, r_q_x[QW]} + 1'b1;
        w_inc_y  = {1'b0, r_q_y[QW]} + 1'b1;
        w_rnd_x  = w_inc_x[QW:1];
        w_rnd_y  = w_inc_y[QW:1];
        w_lim_x  = r_neg_x[QW] ? hpt_pkg::SAT_NEG_MAG : hpt_pkg::SAT_POS_MAG;
        w_lim_y  = r_neg_y[QW] ? hpt_pkg::SAT_NEG_MAG : hpt_pkg::SAT_POS_MAG;
        w_clip_x = r_ov_x[QW] || (w_rnd_x > QW'(w_lim_x));
        w_clip_y = r_ov_y[QW] || (w_rnd_y > QW'(w_lim_y));
    end

    hpt_pkg::t_coord r_out_x, r_out_y;
    logic            r_out_wz, r_out_clip;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_x  <= w_clip_x ? w_lim_x : w_rnd_x[CW-1:0];
            r_mag_y  <= w_clip_y ? w_lim_y : w_rnd_y[CW-1:0];
            r_rc_x   <= w_clip_x;
            r_rc_y   <= w_clip_y;
            r_rneg_x <= r_neg_x[QW];
            r_rneg_y <= r_neg_y[QW];
            r_rwz    <= r_wz[QW];

            // hold zeros and drop the clip flag when w is zero
            r_out_x    <= r_rwz ? '0 : (r_rneg_x ? -r_mag_x : r_mag_x);
            r_out_y    <= r_rwz ? '0 : (r_rneg_y ? -r_mag_y : r_mag_y);
            r_out_wz   <= r_rwz;
            r_out_clip <= !r_rwz && (r_rc_x || r_rc_y);
        end
    end

    assign o_result.valid   = r_vld[STAGES-1];
    assign o_result.out_x   = r_out_x;
    assign o_result.out_y   = r_out_y;
    assign o_result.w_zero  = r_out_wz;
    assign o_result.clipped = r_out_clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_wzero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.w_zero |->
            o_result.out_x == '0 && o_result.out_y == '0 && !o_result.clipped)
        else $error("w_zero result carries nonzero payload");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.clipped |->
            o_result.out_x == hpt_pkg::SAT_POS_MAG || o_result.out_x == hpt_pkg::SAT_NEG_MAG ||
            o_result.out_y == hpt_pkg::SAT_POS_MAG || o_result.out_y == hpt_pkg::SAT_NEG_MAG)
        else $error("clipped result without a saturated coordinate");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

endmodule

`default_nettype wire

// File: test/homogeneous_point_transform_2d_unit_tb.sv
`timescale 1ns / 1ps

module homogeneous_point_transform_2d_unit_tb;

    localparam int unsigned ACC_W       = hpt_pkg::SUM_W + 1;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 60;

    typedef struct packed {
        hpt_pkg::t_coord out_x;
        hpt_pkg::t_coord out_y;
        logic            w_zero;
        logic            clipped;
    } t_point_result;

    logic clk = 1'b0;
    logic rst_n;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [hpt_pkg::CFG_ADDR_W-1:0] paddr;
    logic [hpt_pkg::CFG_DATA_W-1:0] pwdata;
    logic [hpt_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    hpt_point_if  pt_if ();
    hpt_result_if res_if ();

    // Matrix as the block should hold it
    logic [hpt_pkg::CFG_DATA_W-1:0] coef_row0_q;
    logic [hpt_pkg::CFG_DATA_W-1:0] coef_row1_q;
    logic [hpt_pkg::CFG_DATA_W-1:0] coef_row2_q;
    logic [hpt_pkg::CFG_DATA_W-1:0] coef_column2_q;
    logic [hpt_pkg::COEF_W-1:0]     coef_corner_q;

    t_point_result predicted_q[$];
    int            fail_count   = 0;
    bit            tx_idle      = 1'b1;
    bit            rx_idle      = 1'b1;
    bit            hold_request = 1'b0;

    homogeneous_point_transform_2d_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_point  (pt_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Exact three-term sum in Q27.40
    function automatic logic signed [ACC_W-1:0] dot3(input hpt_pkg::t_coord x,
                                                     input hpt_pkg::t_coord y,
                                                     input hpt_pkg::t_coef cx,
                                                     input hpt_pkg::t_coef cy,
                                                     input hpt_pkg::t_coef c1);
        logic signed [ACC_W-1:0] ex, ey, ecx, ecy, ec1;
        ex  = x;
        ey  = y;
        ecx = cx;
        ecy = cy;
        ec1 = c1;
        return ex * ecx + ey * ecy + (ec1 <<< hpt_pkg::FRAC_SHIFT);
    endfunction

    // Returns {clip, value}: num*2^16/den rounded half away from zero, saturated
    function automatic logic [hpt_pkg::COORD_W:0] divide_q16(
            input logic signed [ACC_W-1:0] num,
            input logic signed [ACC_W-1:0] den);
        logic signed [ACC_W-1:0]     num_mag, den_mag;
        logic [127:0]                dividend, quo;
        logic [34:0]                 rounded, limit;
        logic                        negative, clip;
        logic [hpt_pkg::COORD_W-1:0] value;
        negative = num[ACC_W-1] ^ den[ACC_W-1];
        num_mag  = num[ACC_W-1] ? -num : num;
        den_mag  = den[ACC_W-1] ? -den : den;
        dividend = {{(128-ACC_W){1'b0}}, num_mag} << (hpt_pkg::FRAC_SHIFT + 1);
        quo      = dividend / {{(128-ACC_W){1'b0}}, den_mag};
        rounded  = ({1'b0, quo[33:0]} + 35'd1) >> 1;
        limit    = negative ? {3'd0, hpt_pkg::SAT_NEG_MAG} : {3'd0, hpt_pkg::SAT_POS_MAG};
        clip     = 1'b0;
        if ((|quo[127:34]) || rounded > limit) begin
            clip    = 1'b1;
            rounded = limit;
        end
        value = negative ? -rounded[hpt_pkg::COORD_W-1:0] : rounded[hpt_pkg::COORD_W-1:0];
        return {clip, value};
    endfunction

    function automatic t_point_result transform_point(input hpt_pkg::t_coord x,
                                                      input hpt_pkg::t_coord y);
        logic signed [ACC_W-1:0]   xs, ys, ws;
        logic [hpt_pkg::COORD_W:0] qx, qy;
        t_point_result             res;
        xs = dot3(x, y, coef_row0_q[31:0], coef_row1_q[31:0], coef_row2_q[31:0]);
        ys = dot3(x, y, coef_row0_q[63:32], coef_row1_q[63:32], coef_row2_q[63:32]);
        ws = dot3(x, y, coef_column2_q[31:0], coef_column2_q[63:32], coef_corner_q);
        if (ws == '0) begin
            res = '{out_x: '0, out_y: '0, w_zero: 1'b1, clipped: 1'b0};
        end else begin
            qx  = divide_q16(xs, ws);
            qy  = divide_q16(ys, ws);
            res = '{out_x: qx[hpt_pkg::COORD_W-1:0], out_y: qy[hpt_pkg::COORD_W-1:0],
                    w_zero: 1'b0,
                    clipped: qx[hpt_pkg::COORD_W] | qy[hpt_pkg::COORD_W]};
        end
        return res;
    endfunction

    function automatic hpt_pkg::t_coord rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return hpt_pkg::t_coord'($urandom_range(0, 2**21))
                      - hpt_pkg::t_coord'(2**20);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3: return {16'($urandom_range(0, 511) - 256), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic hpt_pkg::t_coef rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return hpt_pkg::t_coef'($urandom_range(0, 2**25)) - hpt_pkg::t_coef'(2**24);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0100_0000;
                    default: return 32'h0000_0000;
                endcase
            end
            3: return hpt_pkg::t_coef'($urandom_range(0, 2**13)) - hpt_pkg::t_coef'(2**12);
            default: return $urandom;
        endcase
    endfunction

    task automatic write_coef_reg(input logic [hpt_pkg::REG_IDX_W-1:0] idx,
                                  input logic [hpt_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {hpt_pkg::REG_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hpt_pkg::REG_COEF_ROW0:    coef_row0_q    = value;
            hpt_pkg::REG_COEF_ROW1:    coef_row1_q    = value;
            hpt_pkg::REG_COEF_ROW2:    coef_row2_q    = value;
            hpt_pkg::REG_COEF_COLUMN2: coef_column2_q = value;
            hpt_pkg::REG_COEF_CORNER:  coef_corner_q  = value[hpt_pkg::COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_matrix(input logic [hpt_pkg::CFG_DATA_W-1:0] row0,
                              input logic [hpt_pkg::CFG_DATA_W-1:0] row1,
                              input logic [hpt_pkg::CFG_DATA_W-1:0] row2,
                              input logic [hpt_pkg::CFG_DATA_W-1:0] col2,
                              input logic [hpt_pkg::CFG_DATA_W-1:0] corner);
        write_coef_reg(hpt_pkg::REG_COEF_ROW0, row0);
        write_coef_reg(hpt_pkg::REG_COEF_ROW1, row1);
        write_coef_reg(hpt_pkg::REG_COEF_ROW2, row2);
        write_coef_reg(hpt_pkg::REG_COEF_COLUMN2, col2);
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, corner);
    endtask

    task automatic send_point(input hpt_pkg::t_coord x, input hpt_pkg::t_coord y);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        do @(posedge clk); while (!pt_if.ready);
        predicted_q.push_back(transform_point(x, y));
    endtask

    // Drop valid and wait until every accepted point has come back
    task automatic drain_results();
        pt_if.valid <= 1'b0;
        while (predicted_q.size() != 0) @(posedge clk);
    endtask

    task automatic check_result();
        t_point_result want;
        if (predicted_q.size() == 0) begin
            $error("unexpected result transfer: out_x %h out_y %h", res_if.out_x, res_if.out_y);
            fail_count++;
        end else begin
            want = predicted_q.pop_front();
            if (res_if.out_x !== want.out_x) begin
                $error("out_x: expected %h, got %h", want.out_x, res_if.out_x);
                fail_count++;
            end
            if (res_if.out_y !== want.out_y) begin
                $error("out_y: expected %h, got %h", want.out_y, res_if.out_y);
                fail_count++;
            end
            if (res_if.w_zero !== want.w_zero) begin
                $error("w_zero: expected %b, got %b", want.w_zero, res_if.w_zero);
                fail_count++;
            end
            if (res_if.clipped !== want.clipped) begin
                $error("clipped: expected %b, got %b", want.clipped, res_if.clipped);
                fail_count++;
            end
        end
    endtask

    task automatic test_reset_identity();
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h0001_0000, 32'hFFFF_0000);
        drain_results();
    endtask

    task automatic test_zero_w();
        // Corner write carries junk in the upper word; only the low word counts
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, 64'hDEAD_BEEF_0000_0000);
        send_point(32'h0000_3039, 32'hFFFF_E57B);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        drain_results();
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, 64'hFFFF_FFFF_0100_0000);
        send_point(32'h0001_8000, 32'hFFFE_8000);
        drain_results();
    endtask

    task automatic test_unmapped_index();
        for (int k = int'(hpt_pkg::REG_COEF_CORNER) + 1; k < 2**hpt_pkg::REG_IDX_W; k++)
            write_coef_reg(hpt_pkg::REG_IDX_W'(k), {$urandom, $urandom});
        send_point(32'h0002_4000, 32'hFFFD_C000);
        drain_results();
    endtask

    task automatic test_rounding_ties();
        // w = 2.0 puts odd LSBs exactly on a half
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, 64'h0200_0000);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h0000_0003, 32'hFFFF_FFFD);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        drain_results();
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, 64'hFE00_0000);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);
        send_point(32'h0000_0005, 32'hFFFF_FFFB);
        drain_results();
    endtask

    task automatic test_saturation();
        set_matrix(64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000, 64'h0, 64'h0, 64'h1);
        send_point(32'h7FFF_FFFF, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0000_0001, 32'h0000_0001);
        drain_results();
        write_coef_reg(hpt_pkg::REG_COEF_CORNER, 64'hFFFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h0000_0001, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_random_matrix(input int count);
        set_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                   {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                   {$urandom, rand_coef()});
        repeat (count) send_point(rand_coord(), rand_coord());
        drain_results();
    endtask

    task automatic test_affine(input int count);
        hpt_pkg::t_coef corner;
        corner = rand_coef();
        if (corner == '0)
            corner = hpt_pkg::RST_COEF_CORNER;
        set_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                   {rand_coef(), rand_coef()}, 64'h0, {32'h0, corner});
        repeat (count) send_point(rand_coord(), rand_coord());
        drain_results();
    endtask

    // w = x - k, so x = k hits zero w and nearby x drives the quotient to saturation
    task automatic test_perspective_zero_w(input int count);
        int              k;
        hpt_pkg::t_coord x_pole;
        hpt_pkg::t_coord x;
        k      = $urandom_range(1, 100);
        x_pole = hpt_pkg::t_coord'(k) <<< hpt_pkg::FRAC_SHIFT;
        set_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                   {rand_coef(), rand_coef()}, {32'h0, hpt_pkg::RST_COEF_CORNER},
                   {32'h0, -(hpt_pkg::t_coef'(k) <<< 24)});
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       x = x_pole;
                1:       x = x_pole + hpt_pkg::t_coord'($urandom_range(0, 64))
                             - hpt_pkg::t_coord'(32);
                default: x = rand_coord();
            endcase
            send_point(x, rand_coord());
        end
        drain_results();
    endtask

    task automatic test_extreme_coefs(input int count);
        set_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                   {2{32'h7FFF_FFFF}}, {32'h0, 32'h7FFF_FFFF});
        repeat (count) send_point(rand_coord(), rand_coord());
        drain_results();
        set_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                   {2{32'h8000_0000}}, {32'h0, 32'h8000_0000});
        repeat (count) send_point(rand_coord(), rand_coord());
        drain_results();
    endtask

    task automatic test_back_to_back(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random_matrix(count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Hold the result side off long enough that the pipeline fills and stalls the input
    task automatic test_backpressure(input int count);
        tx_idle      = 1'b0;
        hold_request = 1'b1;
        test_affine(count);
        tx_idle = 1'b1;
    endtask

    initial begin : result_sink
        res_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            int stall;
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            check_result();
        end
    end

    initial begin
        coef_row0_q    = hpt_pkg::RST_COEF_ROW0;
        coef_row1_q    = hpt_pkg::RST_COEF_ROW1;
        coef_row2_q    = hpt_pkg::RST_COEF_ROW2;
        coef_column2_q = hpt_pkg::RST_COEF_COLUMN2;
        coef_corner_q  = hpt_pkg::RST_COEF_CORNER;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        pt_if.valid   <= 1'b0;
        pt_if.point_x <= '0;
        pt_if.point_y <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_identity();
        test_zero_w();
        test_unmapped_index();
        test_rounding_ties();
        test_saturation();

        test_random_matrix(300);
        test_affine(300);
        test_perspective_zero_w(300);
        test_extreme_coefs(150);
        test_back_to_back(300);
        test_backpressure(150);
        test_random_matrix(100);
        test_perspective_zero_w(100);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
